// ===== hdl/bmhp_pkg.sv =====
// Shared types and constants for the bus message header parser.
package bmhp_pkg;

	typedef enum logic [2:0] {
		K_BODY_SIZE  = 3'd0,
		K_SERIAL     = 3'd1,
		K_FIELD_BYTE = 3'd2,
		K_FIELD_END  = 3'd3,
		K_BODY_BYTE  = 3'd4,
		K_BODY_END   = 3'd5,
		K_MSG_DONE   = 3'd6
	} kind_t;

	localparam logic [7:0] CODE_DEST      = 8'h06;
	localparam logic [7:0] CODE_PATH      = 8'h01;
	localparam logic [7:0] CODE_INTERFACE = 8'h02;
	localparam logic [7:0] CODE_METHOD    = 8'h03;
	localparam logic [7:0] CODE_SIGNATURE = 8'h09;

	localparam int PIDX_W = 5;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         field_code;
		logic [31:0]        value;
		logic [7:0]         text_byte;
		logic [PIDX_W-1:0]  param_index;
		logic               last;
	} res_t;

endpackage

// ===== hdl/bmhp_if.sv =====
// Valid/ready channel interfaces: message bytes in, parse results out.
interface bmhp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       message_start;

	modport source (output valid, output data_byte, output message_start, input ready);
	modport sink (input valid, input data_byte, input message_start, output ready);
endinterface

interface bmhp_res_if;
	import bmhp_pkg::*;
	logic              valid;
	logic              ready;
	kind_t             kind;
	logic [7:0]        field_code;
	logic [31:0]       value;
	logic [7:0]        text_byte;
	logic [PIDX_W-1:0] param_index;
	logic              last;

	modport source (output valid, output kind, output field_code, output value,
		output text_byte, output param_index, output last, input ready);
	modport sink (input valid, input kind, input field_code, input value,
		input text_byte, input param_index, input last, output ready);
endinterface

// ===== hdl/bus_message_header_parser.sv =====
// Byte-serial parser for a bus message header and its string body.
//
// msg carries one message byte per transfer; message_start marks byte 0 and
// restarts the parser before that byte is parsed. res carries results: the
// body size, the serial number, each header field byte, each field end, each
// body string byte, each body parameter end and a final message done.
// A byte causes zero, one or two results; last flags the final one of a byte.
//
// Latency: with an empty queue, results of a byte show on res the cycle after its transfer.
// Throughput: one byte per cycle while bytes give at most one result each and res.ready
// stays high; the result port drains one result per cycle, so a byte with two results
// takes two result transfers. The parser state is updated in the same cycle
// a byte is taken and results go into a four-entry queue; msg.ready is high
// while the queue holds two results or fewer.
//
// Reset clears the queue and returns the parser to the fixed header. When the
// receiver stalls, results wait in the queue and msg.ready drops once the
// queue cannot take two more. Bytes after message done give no results until
// the next message_start.
module bus_message_header_parser #(
	parameter int MAX_BODY_PARAMS = 20
) (
	input  logic           clk,
	input  logic           arst_n,
	bmhp_byte_if.sink      msg,
	bmhp_res_if.source     res
);
	import bmhp_pkg::*;

	localparam int TOP_INT = (MAX_BODY_PARAMS - 1 > 31) ? 31 : MAX_BODY_PARAMS - 1;
	localparam logic [PIDX_W-1:0] PIDX_TOP = PIDX_W'(TOP_INT);

	typedef enum logic [2:0] {
		PH_FIXED = 3'd0,
		PH_FHEAD = 3'd1,
		PH_FSTR  = 3'd2,
		PH_FPAD  = 3'd3,
		PH_BLEN  = 3'd4,
		PH_BSTR  = 3'd5,
		PH_DONE  = 3'd6
	} phase_t;

	phase_t            phase_q, ph;
	logic [3:0]        hcnt_q, hc;
	logic [31:0]       word_q, wd;
	logic [31:0]       body_left_q, bl;
	logic [31:0]       arr_left_q, al;
	logic [7:0]        code_q, cd;
	logic [31:0]       slen_q, sl;
	logic [31:0]       sleft_q, sb;
	logic [2:0]        pad_q, pd;
	logic [7:0]        sig_q, sg;
	logic [PIDX_W-1:0] pnum_q, pn;

	res_t              res_a, res_b;
	logic [1:0]        n_res;

	res_t              fifo_q [4];
	logic [1:0]        wp_q, rp_q;
	logic [2:0]        cnt_q;
	logic              in_xfer, out_xfer;
	logic [1:0]        n_push;

	function automatic res_t mk(kind_t k, logic [7:0] c, logic [31:0] v,
		logic [7:0] t, logic [PIDX_W-1:0] p);
		res_t r;
		r.kind        = k;
		r.field_code  = c;
		r.value       = v;
		r.text_byte   = t;
		r.param_index = p;
		r.last        = 1'b0;
		return r;
	endfunction

	// Next parser state and the results of the byte on msg.
	always_comb begin
		logic [7:0] b;
		logic       fdone;
		logic       hend;
		b     = msg.data_byte;
		fdone = 1'b0;
		hend  = 1'b0;
		n_res = 2'd0;
		res_a = '0;
		res_b = '0;
		if (msg.message_start) begin
			ph = PH_FIXED; hc = '0; wd = '0; bl = '0; al = '0; cd = '0;
			sl = '0; sb = '0; pd = '0; sg = '0; pn = '0;
		end else begin
			ph = phase_q; hc = hcnt_q; wd = word_q; bl = body_left_q; al = arr_left_q;
			cd = code_q; sl = slen_q; sb = sleft_q; pd = pad_q; sg = sig_q; pn = pnum_q;
		end

		unique case (ph)
			PH_FIXED: begin
				if (hc >= 4'd4) wd = {b, wd[31:8]};
				if (hc == 4'd7) begin
					bl    = wd;
					res_a = mk(K_BODY_SIZE, cd, wd, 8'd0, '0);
					n_res = 2'd1;
					hc    = hc + 4'd1;
				end else if (hc == 4'd11) begin
					res_a = mk(K_SERIAL, cd, wd, 8'd0, '0);
					n_res = 2'd1;
					hc    = hc + 4'd1;
				end else if (hc == 4'd15) begin
					al = wd;
					hc = '0;
					if (wd == '0) hend = 1'b1;
					else ph = PH_FHEAD;
				end else begin
					hc = hc + 4'd1;
				end
			end
			PH_FHEAD: begin
				if (al != '0) al = al - 32'd1;
				if (hc == 4'd0) cd = b;
				if (hc >= 4'd4) wd = {b, wd[31:8]};
				if (hc >= 4'd7) begin
					sl = wd;
					sb = wd;
					pd = ~wd[2:0];
					hc = '0;
					ph = PH_FSTR;
				end else begin
					hc = hc + 4'd1;
				end
			end
			PH_FSTR: begin
				if (al != '0) al = al - 32'd1;
				if (sb != '0) begin
					sb    = sb - 32'd1;
					res_a = mk(K_FIELD_BYTE, cd, sl, b, '0);
					n_res = 2'd1;
				end else begin
					res_a = mk(K_FIELD_END, cd, sl, 8'd0, '0);
					n_res = 2'd1;
					if (cd == CODE_SIGNATURE) sg = (sl > 32'd255) ? 8'hff : sl[7:0];
					if (pd != '0) ph = PH_FPAD;
					else fdone = 1'b1;
				end
			end
			PH_FPAD: begin
				if (al != '0) al = al - 32'd1;
				if (pd != '0) pd = pd - 3'd1;
				if (pd == '0) fdone = 1'b1;
			end
			PH_BLEN: begin
				if (bl != '0) bl = bl - 32'd1;
				wd = {b, wd[31:8]};
				if (hc >= 4'd3) begin
					sl = wd;
					sb = wd;
					hc = '0;
					ph = PH_BSTR;
				end else begin
					hc = hc + 4'd1;
				end
			end
			PH_BSTR: begin
				if (bl != '0) bl = bl - 32'd1;
				if (sb != '0) begin
					sb    = sb - 32'd1;
					res_a = mk(K_BODY_BYTE, cd, sl, b, pn);
					n_res = 2'd1;
				end else begin
					res_a = mk(K_BODY_END, cd, sl, 8'd0, pn);
					n_res = 2'd1;
					if (pn < PIDX_TOP) pn = pn + PIDX_W'(1);
					if (bl == '0) begin
						res_b = mk(K_MSG_DONE, cd, 32'd0, 8'd0, '0);
						n_res = 2'd2;
						ph    = PH_DONE;
					end else begin
						ph = PH_BLEN;
						hc = '0;
					end
				end
			end
			default: ph = PH_DONE;
		endcase

		// end of a header field: either next field or end of header
		if (fdone) begin
			if (al == '0) hend = 1'b1;
			else begin
				ph = PH_FHEAD;
				hc = '0;
			end
		end
		if (hend) begin
			if (sg != '0 && bl != '0) begin
				ph = PH_BLEN;
				hc = '0;
				pn = '0;
			end else begin
				if (n_res == 2'd0) res_a = mk(K_MSG_DONE, cd, 32'd0, 8'd0, '0);
				else res_b = mk(K_MSG_DONE, cd, 32'd0, 8'd0, '0);
				n_res = n_res + 2'd1;
				ph    = PH_DONE;
			end
		end

		if (n_res == 2'd1) res_a.last = 1'b1;
		if (n_res == 2'd2) res_b.last = 1'b1;
	end

	assign msg.ready = (cnt_q <= 3'd2);
	assign in_xfer   = msg.valid && msg.ready;
	assign out_xfer  = res.valid && res.ready;
	assign n_push    = in_xfer ? n_res : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FIXED;
			hcnt_q      <= '0;
			word_q      <= '0;
			body_left_q <= '0;
			arr_left_q  <= '0;
			code_q      <= '0;
			slen_q      <= '0;
			sleft_q     <= '0;
			pad_q       <= '0;
			sig_q       <= '0;
			pnum_q      <= '0;
			wp_q        <= '0;
			rp_q        <= '0;
			cnt_q       <= '0;
		end else begin
			if (in_xfer) begin
				phase_q     <= ph;
				hcnt_q      <= hc;
				word_q      <= wd;
				body_left_q <= bl;
				arr_left_q  <= al;
				code_q      <= cd;
				slen_q      <= sl;
				sleft_q     <= sb;
				pad_q       <= pd;
				sig_q       <= sg;
				pnum_q      <= pn;
			end
			wp_q  <= wp_q + n_push;
			if (out_xfer) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {1'b0, n_push} - {2'b00, out_xfer};
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (n_push != 2'd0) fifo_q[wp_q] <= res_a;
		if (n_push == 2'd2) fifo_q[wp_q + 2'd1] <= res_b;
	end

	assign res.valid       = (cnt_q != '0);
	assign res.kind        = fifo_q[rp_q].kind;
	assign res.field_code  = fifo_q[rp_q].field_code;
	assign res.value       = fifo_q[rp_q].value;
	assign res.text_byte   = fifo_q[rp_q].text_byte;
	assign res.param_index = fifo_q[rp_q].param_index;
	assign res.last        = fifo_q[rp_q].last;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("result queue overflow");

	a_two_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		n_push == 2'd2 |-> res_b.kind == K_MSG_DONE && res_b.last && !res_a.last)
		else $error("second result of a byte is not a final message done");

	a_one_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		n_push == 2'd1 |-> res_a.last)
		else $error("single result of a byte not flagged last");

	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(n_push != 2'd0 && ((n_push == 2'd1 && res_a.kind == K_MSG_DONE) ||
		n_push == 2'd2)) |=> phase_q == PH_DONE)
		else $error("message done reported without entering done phase");

	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && phase_q == PH_DONE && !msg.message_start) |-> n_res == 2'd0)
		else $error("result produced after message done");
`endif

endmodule
